// ===== hdl/vcqd_pkg.sv =====
// ----------------------------------------------------------------------------
// vcqd_pkg
// Shared types, constants and scale tables for the coefficient quantizer and
// dequantizer pipeline.
// ----------------------------------------------------------------------------
package vcqd_pkg;

    localparam int unsigned COEF_W   = 16;
    localparam int unsigned QP_W     = 6;
    localparam int unsigned SIZE_W   = 2;
    localparam int unsigned CFG_W    = 6;

    localparam logic [7:0] ROUND_OFFSET = 8'd171;

    // Configuration register indexes
    localparam logic CFG_QP_VALUE  = 1'b0;
    localparam logic CFG_SIZE_CODE = 1'b1;

    // Beat passed from the quantizer to the dequantizer
    typedef struct packed {
        logic signed [COEF_W-1:0] level;
        logic        [15:0]       dscale;
        logic        [SIZE_W-1:0] size_code;
    } t_lvl_beat;

    // qp / 6 for qp in 0..63 by reciprocal multiply (x*43 >> 8)
    function automatic logic [3:0] qp_div6(input logic [QP_W-1:0] qp);
        logic [11:0] prod;
        prod = {6'd0, qp} * 12'd43;
        return prod[11:8];
    endfunction

    function automatic logic [2:0] qp_mod6(input logic [QP_W-1:0] qp);
        logic [6:0] prod;
        prod = {3'd0, qp_div6(qp)} * 7'd6;
        return 3'(qp - prod[5:0]);
    endfunction

    function automatic logic [14:0] fwd_scale(input logic [2:0] qmod);
        logic [14:0] s;
        case (qmod)
            3'd0:    s = 15'd26214;
            3'd1:    s = 15'd23302;
            3'd2:    s = 15'd20560;
            3'd3:    s = 15'd18396;
            3'd4:    s = 15'd16384;
            3'd5:    s = 15'd14564;
            default: s = 15'd0;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] inv_scale(input logic [2:0] qmod);
        logic [6:0] s;
        case (qmod)
            3'd0:    s = 7'd40;
            3'd1:    s = 7'd45;
            3'd2:    s = 7'd51;
            3'd3:    s = 7'd57;
            3'd4:    s = 7'd64;
            3'd5:    s = 7'd72;
            default: s = 7'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== hdl/vcqd_coef_if.sv =====
// ----------------------------------------------------------------------------
// vcqd_coef_if
// Valid/ready channel that carries one transform coefficient per beat.
// ----------------------------------------------------------------------------
interface vcqd_coef_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

// ===== hdl/vcqd_res_if.sv =====
// ----------------------------------------------------------------------------
// vcqd_res_if
// Valid/ready channel that carries a quantized level and its reconstruction.
// ----------------------------------------------------------------------------
interface vcqd_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] level;
    logic signed [15:0] reconstructed;

    modport source (output valid, output level, output reconstructed, input ready);
    modport sink   (input valid, input level, input reconstructed, output ready);
endinterface

// ===== hdl/vcqd_quant.sv =====
// ----------------------------------------------------------------------------
// vcqd_quant
// Three-stage forward quantizer: magnitude and qp split, scale multiply,
// rounding add with shift, sign restore and clip.
// ----------------------------------------------------------------------------
module vcqd_quant import vcqd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [COEF_W-1:0] i_coefficient,
    input  logic        [QP_W-1:0]   i_qp_value,
    input  logic        [SIZE_W-1:0] i_size_code,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_lvl_beat                o_beat
);

    // stage A: magnitude, sign, qp split
    logic               r_a_valid;
    logic [16:0]        r_a_mag;
    logic               r_a_neg;
    logic [2:0]         r_a_qmod;
    logic [3:0]         r_a_qdiv;
    logic [SIZE_W-1:0]  r_a_size;
    // stage B: scaled product
    logic               r_b_valid;
    logic [31:0]        r_b_prod;
    logic               r_b_neg;
    logic [2:0]         r_b_qmod;
    logic [3:0]         r_b_qdiv;
    logic [3:0]         r_b_qshift;
    logic [SIZE_W-1:0]  r_b_size;
    // stage C: level out
    logic               r_c_valid;
    t_lvl_beat          r_c_beat;

    logic en_a, en_b, en_c;

    logic [16:0]        n_a_mag;
    logic [31:0]        n_b_prod;
    logic [3:0]         n_b_qshift;
    logic [32:0]        c_sum;
    logic [32:0]        c_shifted;
    logic [16:0]        c_q;
    logic signed [17:0] c_signed;
    t_lvl_beat          n_c_beat;
    logic [16:0]        c_dscale;

    assign en_c    = !r_c_valid || i_ready;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;
    assign o_valid = r_c_valid;
    assign o_beat  = r_c_beat;

    always_comb begin
        n_a_mag = i_coefficient[COEF_W-1] ? 17'(-{i_coefficient[COEF_W-1], i_coefficient})
                                          : {1'b0, i_coefficient};
    end

    always_comb begin
        n_b_prod   = {15'd0, r_a_mag} * {17'd0, fwd_scale(r_a_qmod)};
        n_b_qshift = 4'd2 + r_a_qdiv + {2'd0, r_a_size};
    end

    always_comb begin
        c_sum     = {1'b0, r_b_prod} + ({25'd0, ROUND_OFFSET} << (5'd5 + {1'b0, r_b_qshift}));
        c_shifted = c_sum >> (5'd14 + {1'b0, r_b_qshift});
        c_q       = c_shifted[16:0];
        c_signed  = r_b_neg ? -$signed({1'b0, c_q}) : $signed({1'b0, c_q});
        if (c_signed > 18'sd32767) begin
            n_c_beat.level = 16'sh7fff;
        end else if (c_signed < -18'sd32768) begin
            n_c_beat.level = 16'sh8000;
        end else begin
            n_c_beat.level = c_signed[15:0];
        end
        c_dscale           = {10'd0, inv_scale(r_b_qmod)} << r_b_qdiv;
        n_c_beat.dscale    = c_dscale[15:0];
        n_c_beat.size_code = r_b_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_valid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a && i_valid) begin
            r_a_mag  <= n_a_mag;
            r_a_neg  <= i_coefficient[COEF_W-1];
            r_a_qmod <= qp_mod6(i_qp_value);
            r_a_qdiv <= qp_div6(i_qp_value);
            r_a_size <= i_size_code;
        end
        if (en_b && r_a_valid) begin
            r_b_prod   <= n_b_prod;
            r_b_neg    <= r_a_neg;
            r_b_qmod   <= r_a_qmod;
            r_b_qdiv   <= r_a_qdiv;
            r_b_qshift <= n_b_qshift;
            r_b_size   <= r_a_size;
        end
        if (en_c && r_b_valid) begin
            r_c_beat <= n_c_beat;
        end
    end

endmodule

// ===== hdl/vcqd_dequant.sv =====
// ----------------------------------------------------------------------------
// vcqd_dequant
// Two-stage dequantizer: level times inverse scale, then rounding add,
// floor shift and clip into the output register.
// ----------------------------------------------------------------------------
module vcqd_dequant import vcqd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_lvl_beat                i_beat,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [COEF_W-1:0] o_level,
    output logic signed [COEF_W-1:0] o_reconstructed
);

    logic                     r_d_valid;
    logic signed [32:0]       r_d_prod;
    logic signed [COEF_W-1:0] r_d_level;
    logic [SIZE_W-1:0]        r_d_size;

    logic                     r_e_valid;
    logic signed [COEF_W-1:0] r_e_level;
    logic signed [COEF_W-1:0] r_e_recon;

    logic en_d, en_e;

    logic signed [32:0]       n_d_prod;
    logic [2:0]               e_dshift;
    logic signed [33:0]       e_sum;
    logic signed [33:0]       e_shifted;
    logic signed [COEF_W-1:0] n_e_recon;

    assign en_e            = !r_e_valid || i_ready;
    assign en_d            = !r_d_valid || en_e;
    assign o_ready         = en_d;
    assign o_valid         = r_e_valid;
    assign o_level         = r_e_level;
    assign o_reconstructed = r_e_recon;

    always_comb begin
        n_d_prod = $signed({{17{i_beat.level[COEF_W-1]}}, i_beat.level})
                 * $signed({17'd0, i_beat.dscale});
    end

    always_comb begin
        e_dshift  = 3'd4 - {1'b0, r_d_size};
        e_sum     = {r_d_prod[32], r_d_prod} + (34'sd1 <<< (e_dshift - 3'd1));
        e_shifted = e_sum >>> e_dshift;
        if (e_shifted > 34'sd32767) begin
            n_e_recon = 16'sh7fff;
        end else if (e_shifted < -34'sd32768) begin
            n_e_recon = 16'sh8000;
        end else begin
            n_e_recon = e_shifted[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (en_d) r_d_valid <= i_valid;
            if (en_e) r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d && i_valid) begin
            r_d_prod  <= n_d_prod;
            r_d_level <= i_beat.level;
            r_d_size  <= i_beat.size_code;
        end
        if (en_e && r_d_valid) begin
            r_e_level <= r_d_level;
            r_e_recon <= n_e_recon;
        end
    end

endmodule

// ===== hdl/video_coeff_quant_dequant_top.sv =====
// ----------------------------------------------------------------------------
// video_coeff_quant_dequant_top
// Streaming coefficient quantizer and dequantizer at 8-bit sample depth.
// ----------------------------------------------------------------------------
// Path: an accepted coefficient beat passes stages A, B, C, D and E in order.
// Throughput: one beat per cycle; the five pipeline registers each hold one
// beat, and a stage advances whenever the stage after it is free or moving.
// Reset (synchronous, active low): clears all stage valid bits, sets qp_value
// and size_code to 0. Payload registers are not reset.
// ----------------------------------------------------------------------------
module video_coeff_quant_dequant_top import vcqd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    // streams
    vcqd_coef_if.sink        i_coef,
    vcqd_res_if.source       o_res
);

    // Configuration registers: write only while the pipe is empty (the block
    // does not enforce it). Each beat samples them at entry and keeps a copy.
    logic [QP_W-1:0]   r_qp_value;
    logic [SIZE_W-1:0] r_size_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qp_value  <= '0;
            r_size_code <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_QP_VALUE:  r_qp_value  <= i_cfg_data[QP_W-1:0];
                CFG_SIZE_CODE: r_size_code <= i_cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Quantizer to dequantizer hand-off
    logic      q_valid;
    logic      q_ready;
    t_lvl_beat q_beat;

    // Stages A..C: magnitude, multiply by forward scale, round/shift/clip
    vcqd_quant u_quant (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_coef.valid),
        .o_ready       (i_coef.ready),
        .i_coefficient (i_coef.coefficient),
        .i_qp_value    (r_qp_value),
        .i_size_code   (r_size_code),
        .o_valid       (q_valid),
        .i_ready       (q_ready),
        .o_beat        (q_beat)
    );

    // Stages D..E: multiply by inverse scale, round/floor-shift/clip.
    // Stage E is the output register; it holds a beat until taken.
    vcqd_dequant u_dequant (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .o_ready         (q_ready),
        .i_beat          (q_beat),
        .o_valid         (o_res.valid),
        .i_ready         (o_res.ready),
        .o_level         (o_res.level),
        .o_reconstructed (o_res.reconstructed)
    );

endmodule

// ===== hdl/vcqd_chk.sv =====
// ----------------------------------------------------------------------------
// vcqd_chk
// Port-level checks on the quantizer/dequantizer top, attached by bind.
// ----------------------------------------------------------------------------
module vcqd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_level,
    input logic [15:0] i_recon
);

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_level) && $stable(i_recon))
        else $error("result beat dropped or changed while stalled");

    // Drain the pipe on reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // An empty output register means every stage can advance.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    // A zero level reconstructs to zero.
    a_zero_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_level == 16'd0 |-> i_recon == 16'd0)
        else $error("nonzero reconstruction of zero level");

    // A positive level never reconstructs negative.
    a_sign_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_level[15] |-> !i_recon[15])
        else $error("reconstruction sign flipped");

endmodule

bind video_coeff_quant_dequant_top vcqd_chk u_vcqd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_coef.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_level     (o_res.level),
    .i_recon     (o_res.reconstructed)
);
